// ===== sv/wsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_pkg: shared types and constants
// Widths, register indexes, status codes and scan phases of the wildcard
// byte signature scanner.
// ----------------------------------------------------------------------------
package wsc_pkg;

   // Field widths
   localparam int BYTE_W    = 8;
   localparam int ADDR_W    = 64;
   localparam int STATUS_W  = 2;
   localparam int POS_W     = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 64;
   localparam int MASK_W    = 16;
   localparam int LEN_W     = 5;
   localparam int OFFS_W    = 6;

   // Pattern registers hold at most this many bytes
   localparam int REG_PATTERN_BYTES = 16;
   // rel32 field size in bytes
   localparam int FIELD_BYTES = 4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_BASE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LOW   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_HIGH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WILDCARD_MASK = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LEN   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RESOLVE       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_FIELD_OFFSET  = 3'd6;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FOUND     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TRUNCATED = 2'd2;

   // Scan phase within one image
   typedef enum logic [1:0] {
      PH_SEARCH,
      PH_WAIT,
      PH_DONE
   } phase_type;

endpackage

// ===== sv/wsc_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_req_if: image byte channel
// One image byte per transaction, with an end-of-image flag.
// ----------------------------------------------------------------------------
interface wsc_req_if;
   logic                       valid;
   logic                       ready;
   logic [wsc_pkg::BYTE_W-1:0] image_byte;
   logic                       last_byte;

   modport source (output valid, output image_byte, output last_byte, input ready);
   modport sink   (input valid, input image_byte, input last_byte, output ready);
endinterface

// ===== sv/wsc_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_rsp_if: scan result channel
// One status and address per image.
// ----------------------------------------------------------------------------
interface wsc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [wsc_pkg::STATUS_W-1:0] scan_status;
   logic [wsc_pkg::ADDR_W-1:0]   result_address;

   modport source (output valid, output scan_status, output result_address, input ready);
   modport sink   (input valid, input scan_status, input result_address, output ready);
endinterface

// ===== sv/wsc_csr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_csr_if: register write channel
// Register index and write data per transaction.
// ----------------------------------------------------------------------------
interface wsc_csr_if;
   logic                          valid;
   logic                          ready;
   logic [wsc_pkg::CSR_IDX_W-1:0] index;
   logic [wsc_pkg::CSR_DAT_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/wildcard_byte_signature_scanner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_byte_signature_scanner: masked byte pattern search
// Streams an image byte by byte, finds the first masked pattern match and
// reports its address or the resolved rel32 target.
// ----------------------------------------------------------------------------
// Takes one image byte per clock unless results stall, and gives exactly one
// result per image. A byte is captured in an input register and evaluated
// by a single compare stage against a history line of the most recent
// pattern-sized bytes; the result lands in an output register. Throughput
// is one byte per cycle, limited only by that compare stage and by
// backpressure on the result channel. Found is reported on the byte
// completing the match (plain mode, or resolve mode with the field inside
// the pattern) or on the last byte of a rel32 field beyond it; otherwise the
// byte flagged last gives not found or truncated. Bytes after a found result
// are consumed silently until the last byte. Register writes are accepted
// every cycle and should only be issued while no transaction is in flight.
module wildcard_byte_signature_scanner #(
   parameter int PATTERN_MAX = 16
) (
   input  logic      clock,
   input  logic      reset,
   wsc_req_if.sink   req_chan,
   wsc_rsp_if.source rsp_chan,
   wsc_csr_if.sink   csr_chan
);

   // Usable pattern bytes and history depth (rel32 field needs four taps)
   localparam int CAP   = (PATTERN_MAX < wsc_pkg::REG_PATTERN_BYTES) ?
                          PATTERN_MAX : wsc_pkg::REG_PATTERN_BYTES;
   localparam int WIN   = (CAP < wsc_pkg::FIELD_BYTES) ? wsc_pkg::FIELD_BYTES : CAP;
   localparam int WIN_W = $clog2(WIN);
   localparam int LEN_W = wsc_pkg::LEN_W;
   localparam int POS_W = wsc_pkg::POS_W;
   localparam int ADDR_W = wsc_pkg::ADDR_W;
   localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAP);
   localparam logic [LEN_W-1:0] FIELD_LAST = LEN_W'(wsc_pkg::FIELD_BYTES - 1);

   // Configuration registers
   logic [ADDR_W-1:0]              image_base_ff;
   logic [63:0]                    pattern_low_ff;
   logic [63:0]                    pattern_high_ff;
   logic [wsc_pkg::MASK_W-1:0]     wildcard_mask_ff;
   logic [LEN_W-1:0]               pattern_length_ff;
   logic                           resolve_ff;
   logic [wsc_pkg::OFFS_W-1:0]     field_offset_ff;

   // Input stage
   logic                           in_valid_ff;
   logic [wsc_pkg::BYTE_W-1:0]     in_byte_ff;
   logic                           in_last_ff;

   // Scan state
   logic [wsc_pkg::BYTE_W-1:0]     win_ff [WIN];
   logic [wsc_pkg::BYTE_W-1:0]     win_in [WIN];
   logic [POS_W-1:0]               pos_ff, pos_in;
   logic [POS_W-1:0]               ms_ff, ms_in;
   wsc_pkg::phase_type             phase_ff, phase_in;

   // Output stage
   logic                           out_valid_ff;
   logic [wsc_pkg::STATUS_W-1:0]   status_ff, status_in;
   logic [ADDR_W-1:0]              addr_ff, addr_in;

   // Stage control
   logic                           advance;
   logic                           accept;
   logic                           emit;

   // Match datapath
   logic [LEN_W-1:0]               len, len_m1, tap, end_back, fidx;
   logic [127:0]                   pat_bytes;
   logic                           hit, immediate, wait_hit, searchable;
   logic [POS_W-1:0]               pos_next, ms_new, ms_sel;
   logic [31:0]                    raw;
   logic [ADDR_W-1:0]              target;

   assign advance = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign accept  = req_chan.valid && req_chan.ready;

   assign req_chan.ready       = !in_valid_ff || advance;
   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.scan_status = status_ff;
   assign rsp_chan.result_address = addr_ff;
   assign csr_chan.ready       = 1'b1;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         image_base_ff     <= '0;
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         wildcard_mask_ff  <= '0;
         pattern_length_ff <= LEN_W'(1);
         resolve_ff        <= 1'b0;
         field_offset_ff   <= '0;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            wsc_pkg::REG_IMAGE_BASE:    image_base_ff     <= csr_chan.data;
            wsc_pkg::REG_PATTERN_LOW:   pattern_low_ff    <= csr_chan.data;
            wsc_pkg::REG_PATTERN_HIGH:  pattern_high_ff   <= csr_chan.data;
            wsc_pkg::REG_WILDCARD_MASK: wildcard_mask_ff  <= csr_chan.data[wsc_pkg::MASK_W-1:0];
            wsc_pkg::REG_PATTERN_LEN:   pattern_length_ff <= csr_chan.data[LEN_W-1:0];
            wsc_pkg::REG_RESOLVE:       resolve_ff        <= csr_chan.data[0];
            wsc_pkg::REG_FIELD_OFFSET:  field_offset_ff   <= csr_chan.data[wsc_pkg::OFFS_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective pattern length: zero means one, clamp to capacity
   always_comb begin
      len = pattern_length_ff;
      if (len == '0) len = LEN_W'(1);
      if (len > CAP_LEN) len = CAP_LEN;
      len_m1 = len - LEN_W'(1);
   end

   // New byte enters the history line at tap 0 (newest)
   always_comb begin
      win_in[0] = in_byte_ff;
      for (int k = 1; k < WIN; k++) win_in[k] = win_ff[k-1];
   end

   // Masked compare: pattern byte j sits len-1-j taps back
   assign pat_bytes = {pattern_high_ff, pattern_low_ff};
   always_comb begin
      hit = 1'b1;
      tap = '0;
      for (int j = 0; j < CAP; j++) begin
         tap = len_m1 - LEN_W'(j);
         if ((LEN_W'(j) < len) && !wildcard_mask_ff[j] &&
             (win_in[tap[WIN_W-1:0]] != pat_bytes[8*j +: 8])) begin
            hit = 1'b0;
         end
      end
   end

   // Positions and rel32 field gathering
   assign pos_next   = pos_ff + POS_W'(1);
   assign searchable = pos_next >= POS_W'(len);
   assign ms_new     = pos_next - POS_W'(len);
   assign ms_sel     = (phase_ff == wsc_pkg::PH_SEARCH) ? ms_new : ms_ff;
   assign immediate  = ({1'b0, field_offset_ff} + 7'(FIELD_LAST)) <= 7'(len_m1);
   assign wait_hit   = pos_ff == (ms_ff + POS_W'(field_offset_ff) + POS_W'(FIELD_LAST));
   // Field end is len-1-offset-3 taps back when inside the pattern, else newest
   assign end_back   = immediate ? (len_m1 - LEN_W'(field_offset_ff) - FIELD_LAST) : '0;

   always_comb begin
      raw  = '0;
      fidx = '0;
      for (int i = 0; i < wsc_pkg::FIELD_BYTES; i++) begin
         fidx = end_back + FIELD_LAST - LEN_W'(i);
         raw[8*i +: 8] = win_in[fidx[WIN_W-1:0]];
      end
   end

   assign target = image_base_ff + ADDR_W'(ms_sel) + {{32{raw[31]}}, raw} +
                   ADDR_W'(field_offset_ff) + ADDR_W'(wsc_pkg::FIELD_BYTES);

   // Per-byte scan step
   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      ms_in     = ms_ff;
      emit      = 1'b0;
      status_in = wsc_pkg::STATUS_FOUND;
      addr_in   = target;
      unique case (phase_ff)
         wsc_pkg::PH_SEARCH: begin
            pos_in = pos_next;
            if (searchable && hit) begin
               ms_in = ms_new;
               if (!resolve_ff) begin
                  emit     = 1'b1;
                  addr_in  = image_base_ff + ADDR_W'(ms_new);
                  phase_in = wsc_pkg::PH_DONE;
               end else if (immediate) begin
                  emit     = 1'b1;
                  phase_in = wsc_pkg::PH_DONE;
               end else begin
                  phase_in = wsc_pkg::PH_WAIT;
               end
            end
         end
         wsc_pkg::PH_WAIT: begin
            pos_in = pos_next;
            if (wait_hit) begin
               emit     = 1'b1;
               phase_in = wsc_pkg::PH_DONE;
            end
         end
         default: ;
      endcase
      // End of image: report a miss if nothing was reported, then restart
      if (in_last_ff) begin
         if (!emit && phase_ff != wsc_pkg::PH_DONE) begin
            emit      = 1'b1;
            addr_in   = '0;
            status_in = (phase_in == wsc_pkg::PH_WAIT) ?
                        wsc_pkg::STATUS_TRUNCATED : wsc_pkg::STATUS_NOT_FOUND;
         end
         phase_in = wsc_pkg::PH_SEARCH;
         pos_in   = '0;
         ms_in    = '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= wsc_pkg::PH_SEARCH;
         pos_ff       <= '0;
         ms_ff        <= '0;
      end else begin
         if (accept) in_valid_ff <= 1'b1;
         else if (advance) in_valid_ff <= 1'b0;
         if (advance && emit) out_valid_ff <= 1'b1;
         else if (rsp_chan.ready) out_valid_ff <= 1'b0;
         if (advance) begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
            ms_ff    <= ms_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_chan.image_byte;
         in_last_ff <= req_chan.last_byte;
      end
      if (advance && phase_ff != wsc_pkg::PH_DONE) begin
         win_ff <= win_in;
      end
      if (advance && emit) begin
         status_ff <= status_in;
         addr_ff   <= addr_in;
      end
   end

`ifndef SYNTHESIS
   // A found result that is not the image's end leaves the scan done
   assert property (@(posedge clock) disable iff (reset)
      (advance && emit && !in_last_ff) |=> (phase_ff == wsc_pkg::PH_DONE))
      else $error("scan not done after a result");

   // A last byte seen before any result always produces one
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff && phase_ff != wsc_pkg::PH_DONE) |=> out_valid_ff)
      else $error("image ended without a result");

   // End of image restarts the search at position zero
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> (pos_ff == '0 && phase_ff == wsc_pkg::PH_SEARCH))
      else $error("image end did not restart the scan");

   // Misses carry a zero address
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && status_ff != wsc_pkg::STATUS_FOUND) |-> (addr_ff == '0))
      else $error("nonzero address on a miss");
`endif

endmodule

// ===== dv/wsc_scan_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsc_scan_checker: result predictor and scoreboard for the byte scanner
// Watches the register, image byte and result channels, replays every
// accepted byte through a cycle-free model of the masked search and compares
// each accepted result, field by field, with the oldest owed result.
// ----------------------------------------------------------------------------
module wsc_scan_checker (
   input  logic clock,
   input  logic reset,
   wsc_req_if   req_mon,
   wsc_rsp_if   rsp_mon,
   wsc_csr_if   csr_mon,
   output int   pending,
   output int   fail_count
);
   import wsc_pkg::*;

   localparam int HIST = 64;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   addr;
   } scan_result_type;

   // Register copies
   logic [ADDR_W-1:0]        base_addr;
   logic [2*CSR_DAT_W-1:0]   pattern_bytes;
   logic [MASK_W-1:0]        wc_mask;
   logic [LEN_W-1:0]         pat_len;
   logic                     resolve_en;
   logic [OFFS_W-1:0]        fld_offs;

   // Scan state; recent[0] is the newest byte
   logic [BYTE_W-1:0]        recent [0:HIST-1];
   logic [POS_W-1:0]         img_pos;
   logic [POS_W-1:0]         match_pos;
   phase_type                scan_state;

   scan_result_type          owed_results [$];

   task automatic report(input string what);
      $display("[%0t] scanner mismatch: %s", $time, what);
      fail_count++;
   endtask

   task automatic restart_image();
      img_pos    = '0;
      match_pos  = '0;
      scan_state = PH_SEARCH;
   endtask

   task automatic owe(input logic [STATUS_W-1:0] status, input logic [ADDR_W-1:0] addr);
      scan_result_type r;
      r.status = status;
      r.addr   = addr;
      owed_results.insert(owed_results.size(), r);
   endtask

   // Target of the little-endian rel32 field, counted from the end of the field
   function automatic logic [ADDR_W-1:0] rel32_target(input logic [POS_W-1:0] pos);
      logic [31:0]      raw;
      logic [POS_W-1:0] back;
      int               i;
      for (i = 0; i < FIELD_BYTES; i++) begin
         back = pos - (match_pos + POS_W'(fld_offs) + POS_W'(i));
         raw[8*i +: 8] = recent[back[5:0]];
      end
      return base_addr + {32'b0, match_pos} + {{32{raw[31]}}, raw}
             + {58'b0, fld_offs} + 64'(FIELD_BYTES);
   endfunction

   // One image byte through the search
   task automatic advance_scan(input logic [BYTE_W-1:0] b, input logic last);
      int unsigned      n;
      int unsigned      j;
      logic [POS_W-1:0] pos;
      logic             hit;
      logic             gave;
      gave = 1'b0;
      if (scan_state == PH_DONE) begin
         // bytes after a hit are dropped until the end of the image
         if (last)
            restart_image();
         return;
      end
      for (j = HIST - 1; j > 0; j--)
         recent[j] = recent[j-1];
      recent[0] = b;
      pos       = img_pos;
      img_pos   = pos + POS_W'(1);

      if (scan_state == PH_SEARCH) begin
         // length zero acts as one, anything above the register capacity is capped
         n = (pat_len == 0) ? 1 :
             ((pat_len > REG_PATTERN_BYTES) ? REG_PATTERN_BYTES : int'(pat_len));
         // position compare wraps at 32 bits
         if (pos + POS_W'(1) >= POS_W'(n)) begin
            hit = 1'b1;
            for (j = 0; j < n; j++)
               if (!wc_mask[j] && recent[n-1-j] != pattern_bytes[8*j +: 8])
                  hit = 1'b0;
            if (hit) begin
               match_pos = pos + 1 - POS_W'(n);
               if (!resolve_en) begin
                  owe(STATUS_FOUND, base_addr + {32'b0, match_pos});
                  gave       = 1'b1;
                  scan_state = PH_DONE;
               end else if (int'(fld_offs) + FIELD_BYTES - 1 <= int'(n) - 1) begin
                  // field lies inside the matched bytes
                  owe(STATUS_FOUND, rel32_target(pos));
                  gave       = 1'b1;
                  scan_state = PH_DONE;
               end else begin
                  scan_state = PH_WAIT;
               end
            end
         end
      end else if (scan_state == PH_WAIT) begin
         if (pos == match_pos + POS_W'(fld_offs) + POS_W'(FIELD_BYTES - 1)) begin
            owe(STATUS_FOUND, rel32_target(pos));
            gave       = 1'b1;
            scan_state = PH_DONE;
         end
      end

      if (last) begin
         if (!gave)
            owe((scan_state == PH_WAIT) ? STATUS_TRUNCATED : STATUS_NOT_FOUND, '0);
         restart_image();
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      case (idx)
         REG_IMAGE_BASE:    base_addr = data;
         REG_PATTERN_LOW:   pattern_bytes[63:0] = data;
         REG_PATTERN_HIGH:  pattern_bytes[127:64] = data;
         REG_WILDCARD_MASK: wc_mask = data[MASK_W-1:0];
         REG_PATTERN_LEN:   pat_len = data[LEN_W-1:0];
         REG_RESOLVE:       resolve_en = data[0];
         REG_FIELD_OFFSET:  fld_offs = data[OFFS_W-1:0];
         default: ;
      endcase
   endtask

   task automatic check_result(input logic [STATUS_W-1:0] status,
                               input logic [ADDR_W-1:0] addr);
      scan_result_type want;
      if (owed_results.size() == 0) begin
         report($sformatf("unexpected result status %0d address %h", status, addr));
         return;
      end
      want = owed_results.pop_front();
      if (status !== want.status)
         report($sformatf("scan_status %0d, expected %0d", status, want.status));
      if (addr !== want.addr)
         report($sformatf("result_address %h, expected %h", addr, want.addr));
   endtask

   // Results are checked before the byte of the same edge is predicted
   always @(posedge clock) begin
      if (reset) begin
         int k;
         base_addr     = '0;
         pattern_bytes = '0;
         wc_mask       = '0;
         pat_len       = LEN_W'(1);
         resolve_en    = 1'b0;
         fld_offs      = '0;
         for (k = 0; k < HIST; k++)
            recent[k] = '0;
         restart_image();
         owed_results.delete();
         fail_count = 0;
         pending   <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready)
            check_result(rsp_mon.scan_status, rsp_mon.result_address);
         if (csr_mon.valid && csr_mon.ready)
            write_reg(csr_mon.index, csr_mon.data);
         if (req_mon.valid && req_mon.ready)
            advance_scan(req_mon.image_byte, req_mon.last_byte);
         pending <= owed_results.size();
      end
   end

endmodule

// ===== dv/wildcard_byte_signature_scanner_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_byte_signature_scanner_test: top level of the scanner testbench
// Drives register settings and images into the scanner, with a directed
// opening and random phases that mostly plant the pattern and rel32 field in
// random bytes; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module wildcard_byte_signature_scanner_test;
   import wsc_pkg::*;

   localparam int RANDOM_ITEMS = 1900;
   localparam int PHASE_ITEMS  = 150;
   localparam int IDLE_PCT     = 8;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 200000;
   // index with no register behind it
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   logic              clock;
   logic              reset;
   int                pending;
   int                fail_count;
   int                cycle_count;
   int                fed_count;
   logic              calm;
   logic              hold_go;
   logic [BYTE_W-1:0] img_q [$];

   // Settings of the current phase, used to shape images
   logic [ADDR_W-1:0] cfg_base;
   logic [63:0]       cfg_lo;
   logic [63:0]       cfg_hi;
   logic [MASK_W-1:0] cfg_mask;
   logic [LEN_W-1:0]  cfg_len;
   logic              cfg_res;
   logic [OFFS_W-1:0] cfg_fo;

   wsc_req_if req_bus ();
   wsc_rsp_if rsp_bus ();
   wsc_csr_if csr_bus ();

   wildcard_byte_signature_scanner u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   wsc_scan_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_bus),
      .rsp_mon    (rsp_bus),
      .csr_mon    (csr_bus),
      .pending    (pending),
      .fail_count (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Run limit
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("wildcard_byte_signature_scanner_test NOT OK");
      $finish;
   end

   // Result side: random stalls, one long hold-off during the pressure phase
   initial begin : result_sink
      int   held;
      logic hold_done;
      hold_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && !hold_done) begin
            rsp_bus.ready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++)
               @(posedge clock);
            hold_done = 1'b1;
         end
         rsp_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      csr_bus.valid <= 1'b1;
      @(posedge clock);
      while (!csr_bus.ready)
         @(posedge clock);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Sends img_q as one image, last flag on the final byte
   task automatic feed_image();
      int k;
      for (k = 0; k < img_q.size(); k++) begin
         while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
         req_bus.valid      <= 1'b1;
         req_bus.image_byte <= img_q[k];
         req_bus.last_byte  <= (k == img_q.size() - 1);
         @(posedge clock);
         while (!req_bus.ready)
            @(posedge clock);
         fed_count++;
      end
   endtask

   // Wait until every owed result is in, then let the pipeline drain
   task automatic quiesce();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Narrow registers get random junk above their width
   task automatic apply_config();
      csr_write(REG_IMAGE_BASE, cfg_base);
      csr_write(REG_PATTERN_LOW, cfg_lo);
      csr_write(REG_PATTERN_HIGH, cfg_hi);
      csr_write(REG_WILDCARD_MASK, {$urandom, 16'($urandom), cfg_mask});
      csr_write(REG_PATTERN_LEN, {$urandom, 27'($urandom), cfg_len});
      csr_write(REG_RESOLVE, {$urandom, 31'($urandom), cfg_res});
      csr_write(REG_FIELD_OFFSET, {$urandom, 26'($urandom), cfg_fo});
      csr_write(REG_UNUSED, {$urandom, $urandom});
   endtask

   // Mostly a planted match plus field bytes, some pure noise, some cut short
   task automatic build_image(input logic short_form);
      int           n;
      int           pre;
      int           cut;
      int           j;
      logic [127:0] pat;
      img_q.delete();
      n   = (cfg_len == 0) ? 1 : ((cfg_len > REG_PATTERN_BYTES) ? REG_PATTERN_BYTES : cfg_len);
      pat = {cfg_hi, cfg_lo};
      if ($urandom_range(0, 99) < 25) begin
         repeat ($urandom_range(1, short_form ? 3 : 30))
            img_q.insert(img_q.size(), 8'($urandom));
      end else begin
         pre = short_form ? $urandom_range(0, 1) : $urandom_range(0, 12);
         repeat (pre) img_q.insert(img_q.size(), 8'($urandom));
         for (j = 0; j < n; j++)
            img_q.insert(img_q.size(), cfg_mask[j] ? 8'($urandom) : pat[8*j +: 8]);
         if (cfg_res)
            while (img_q.size() < pre + cfg_fo + FIELD_BYTES)
               img_q.insert(img_q.size(), 8'($urandom));
         if (!short_form) begin
            repeat ($urandom_range(0, 6)) img_q.insert(img_q.size(), 8'($urandom));
            if ($urandom_range(0, 99) < 15) begin
               cut = $urandom_range(1, img_q.size());
               while (img_q.size() > cut)
                  void'(img_q.pop_back());
            end
         end
      end
   endtask

   initial begin : stimulus
      int   phase_idx;
      int   goal;
      logic short_form;

      req_bus.valid      <= 1'b0;
      req_bus.image_byte <= '0;
      req_bus.last_byte  <= 1'b0;
      csr_bus.valid      <= 1'b0;
      csr_bus.index      <= REG_IMAGE_BASE;
      csr_bus.data       <= '0;
      reset              <= 1'b1;
      calm      = 1'b0;
      hold_go   = 1'b0;
      fed_count = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: one zero byte pattern, plain mode
      img_q = '{8'h00};
      feed_image();
      // hit in the middle, trailing last byte ignored
      img_q = '{8'h12, 8'h00, 8'h34};
      feed_image();
      img_q = '{8'hFF};
      feed_image();
      quiesce();

      // Length zero acts as one; address wraps past the top of memory
      csr_write(REG_IMAGE_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(REG_PATTERN_LOW, 64'h0000_0000_0000_00AB);
      csr_write(REG_PATTERN_LEN, 64'd0);
      img_q = '{8'h01, 8'hAB};
      feed_image();
      quiesce();

      // Field inside the pattern, negative rel32, hit on the last byte
      csr_write(REG_IMAGE_BASE, 64'h1000);
      csr_write(REG_PATTERN_LEN, 64'd8);
      csr_write(REG_WILDCARD_MASK, 64'h00FF);
      csr_write(REG_RESOLVE, 64'd1);
      csr_write(REG_FIELD_OFFSET, 64'd4);
      img_q = '{8'h11, 8'h22, 8'h33, 8'h44, 8'h00, 8'h00, 8'h00, 8'h80};
      feed_image();
      quiesce();

      // Image ends before a far field: truncated
      csr_write(REG_PATTERN_LEN, 64'd1);
      csr_write(REG_WILDCARD_MASK, 64'h0001);
      csr_write(REG_FIELD_OFFSET, 64'd63);
      img_q = '{8'h5A, 8'hA5};
      feed_image();
      quiesce();

      // Field after the pattern, resolved on its last byte
      csr_write(REG_FIELD_OFFSET, 64'd1);
      img_q = '{8'hAA, 8'h01, 8'h02, 8'h03, 8'h04};
      feed_image();
      quiesce();

      // Random phases
      fed_count = 0;
      phase_idx = 0;
      while (fed_count < RANDOM_ITEMS) begin
         cfg_base = {$urandom, $urandom};
         cfg_lo   = {$urandom, $urandom};
         cfg_hi   = {$urandom, $urandom};
         cfg_mask = ($urandom_range(0, 3) == 0) ? '0 : MASK_W'($urandom & $urandom & $urandom);
         if ($urandom_range(0, 9) == 0)
            cfg_len = $urandom_range(0, 1) ? '0 : LEN_W'($urandom_range(17, 31));
         else
            cfg_len = LEN_W'($urandom_range(1, 16));
         cfg_res = 1'($urandom_range(0, 1));
         cfg_fo  = ($urandom_range(0, 4) == 0) ? OFFS_W'($urandom_range(0, 63))
                                                : OFFS_W'($urandom_range(0, 12));
         case (phase_idx)
            0: begin
               cfg_base = '0;
               cfg_mask = '0;
               cfg_len  = LEN_W'(16);
               cfg_res  = 1'b0;
               cfg_fo   = '0;
            end
            1: begin
               cfg_base = '1;
               cfg_mask = '1;
               cfg_len  = LEN_W'(16);
               cfg_res  = 1'b1;
               cfg_fo   = '1;
            end
            2: begin
               cfg_len = LEN_W'($urandom_range(1, 3));
               cfg_res = 1'b0;
            end
            default: ;
         endcase
         apply_config();

         // phase 2 floods short images into a stalled result side
         short_form = (phase_idx == 2);
         hold_go    = short_form;
         calm       = (phase_idx == 4);
         goal       = fed_count + PHASE_ITEMS;
         while (fed_count < goal) begin
            build_image(short_form);
            feed_image();
         end
         quiesce();
         calm    = 1'b0;
         hold_go = 1'b0;
         phase_idx++;
      end

      if (fail_count == 0)
         $display("wildcard_byte_signature_scanner_test OK");
      else
         $display("wildcard_byte_signature_scanner_test NOT OK");
      $finish;
   end

endmodule
